[hdl/audio_auto_gain_adjust_core_macros.svh]
// Assertion macros for the audio automatic gain adjust core.
// Depends on nothing; included by the top level only.
`ifndef AUDIO_AUTO_GAIN_ADJUST_CORE_MACROS_SVH
`define AUDIO_AUTO_GAIN_ADJUST_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define AGA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define AGA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AGA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define AGA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/aga_pkg.sv]
// Shared types and constants of the audio automatic gain adjust core.
// No dependencies; used by audio_auto_gain_adjust_core.
package aga_pkg;

  // Q.16 levels and decision thresholds
  localparam logic [16:0] Q_ONE       = 17'd65536;
  localparam logic [16:0] MAX17       = 17'd131071;
  localparam logic [16:0] LOWER_HI    = 17'd16384;  // average above 0.25
  localparam logic [16:0] LOWER_LO    = 17'd3276;   // average above 0.05
  localparam logic [16:0] RAISE_LIM   = 17'd13108;  // average below 0.20
  localparam logic [16:0] GAIN_UP_MAX = 17'd72088;  // largest gain after a raise

  localparam logic [17:0] RATE_RESET  = 18'd48000;
  localparam int          CHANNELS_DEF = 8;

  // Constant divisors of the gain step
  localparam logic [3:0]  DIV_DOWN = 4'd11;
  localparam logic [3:0]  DIV_UP   = 4'd10;

  // Adjustment codes
  localparam logic [1:0]  ADJ_NONE = 2'd0;
  localparam logic [1:0]  ADJ_DOWN = 2'd1;
  localparam logic [1:0]  ADJ_UP   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DECIDE,
    ST_SCALE,
    ST_DONE
  } aga_state_e;

  // Per-channel state entry
  typedef struct packed {
    logic [16:0] avg;
    logic [20:0] cnt;
    logic [16:0] gain;
  } aga_entry_t;

endpackage

[hdl/audio_auto_gain_adjust_core.sv]
// Audio automatic gain adjust core: per-channel weighted average volume and slow gain steps.
// Bit-serial multiply, restoring divide and constant-ratio scaling around a channel memory.
// Depends on aga_pkg and audio_auto_gain_adjust_core_macros.svh.
// Flow: a zero-sample or out-of-range item goes from read and load straight to the output;
//   an update adds multiply, divide and decide, and scaling when the gain moves (21 multiply
//   bits, 17 quotient bits, 18 scaling bits). Multiply and divide run one bit per cycle;
//   the next request is taken once the result is in the output register.
// Reset: clears all channel valid bits, so every channel reads average 1.0, counter 0 and
//   unity gain; sample rate returns to 48000. No clearing pass is needed.
`include "audio_auto_gain_adjust_core_macros.svh"

module audio_auto_gain_adjust_core #(
  parameter int CHANNELS = aga_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: sample rate in hertz
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_data_i,
  // request input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [16:0] block_volume, [32:17] block_samples, rest 0
  input  logic [2:0]  s_axis_tuser,   // [2:0] channel
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [16:0] gain, [33:17] average_volume,
                                      // [35:34] adjustment, rest 0
  output logic [2:0]  m_axis_tuser    // [2:0] channel_out
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam aga_pkg::aga_entry_t ENTRY_RESET = '{
    avg:  aga_pkg::Q_ONE,
    cnt:  21'd0,
    gain: aga_pkg::Q_ONE
  };

  // x * 10 and x * 11 by shift and add
  function automatic logic [20:0] times10(input logic [16:0] x);
    return 21'({x, 3'b000}) + 21'({x, 1'b0});
  endfunction

  function automatic logic [20:0] times11(input logic [16:0] x);
    return times10(x) + 21'(x);
  endfunction

  // One restoring step of a division by a small constant: {remainder, shifter}
  function automatic logic [21:0] scale_step(input logic [3:0]  rem,
                                             input logic [17:0] sh,
                                             input logic [3:0]  dv);
    logic [4:0] t;
    logic       ge;
    logic [3:0] r;
    t  = {rem, sh[17]};
    ge = (t >= {1'b0, dv});
    r  = ge ? 4'(t - {1'b0, dv}) : t[3:0];
    return {r, sh[16:0], ge};
  endfunction

  // Saturate an 18-bit quotient to 17 bits
  function automatic logic [16:0] sat17(input logic [17:0] q);
    return q[17] ? aga_pkg::MAX17 : q[16:0];
  endfunction

  // Control registers
  aga_pkg::aga_state_e state_q, state_d;
  logic                m_valid_q, m_valid_d;
  logic [CHANNELS-1:0] valid_q;
  logic [17:0]         rate_q;

  // Payload registers
  logic [2:0]  ch_q, ch_d;
  logic [16:0] vol_q, vol_d;
  logic [15:0] n_q, n_d;
  logic        upd_q, upd_d;
  logic [16:0] avg_m_q, avg_m_d;
  logic [20:0] cnt_sh_q, cnt_sh_d;
  logic [15:0] n_sh_q, n_sh_d;
  logic [38:0] acc_q, acc_d;
  logic [21:0] tot_q, tot_d;
  logic [21:0] rem_q, rem_d;
  logic [16:0] dvd_q, dvd_d;
  logic [4:0]  bit_q, bit_d;
  logic [16:0] gain_q, gain_d;
  logic [16:0] avg_q, avg_d;
  logic [20:0] cnt_new_q, cnt_new_d;
  logic [1:0]  adj_q, adj_d;
  logic        lower_q, lower_d;
  logic [3:0]  sg_rem_q, sg_rem_d, sa_rem_q, sa_rem_d;
  logic [17:0] sg_sh_q, sg_sh_d, sa_sh_q, sa_sh_d;
  logic [39:0] m_data_q, m_data_d;
  logic [2:0]  m_user_q, m_user_d;

  // Channel memory
  aga_pkg::aga_entry_t chan_mem_q [CHANNELS];
  aga_pkg::aga_entry_t rd_entry_q;
  aga_pkg::aga_entry_t cur_entry;
  aga_pkg::aga_entry_t wr_entry;
  logic                mem_we;

  logic [6:0]  ch_ext;
  logic [AW-1:0] addr;
  logic        in_range;
  logic        in_acc;
  logic        out_free;
  logic [18:0] mul_hi;
  logic [38:0] acc_sum;
  logic [22:0] div_trial;
  logic        div_ge;
  logic [20:0] six_sec;
  logic [20:0] four_sec;
  logic        trip;
  logic        lower;
  logic        raise;
  logic [20:0] dg, da;
  logic [3:0]  sdiv;
  logic [21:0] sg_step, sa_step;
  logic        out_oor;

  // Channel decode
  assign ch_ext   = {4'b0000, ch_q};
  assign addr     = ch_ext[AW-1:0];
  assign in_range = (ch_ext < 7'(CHANNELS));
  assign cur_entry = valid_q[addr] ? rd_entry_q : ENTRY_RESET;
  assign wr_entry  = '{avg: avg_q, cnt: cnt_new_q, gain: gain_q};

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Multiply step: add both partial products at the top, shift right
  assign mul_hi = {1'b0, acc_q[38:21]}
                + (cnt_sh_q[0] ? {2'b00, avg_m_q} : 19'd0)
                + (n_sh_q[0]   ? {2'b00, vol_q}   : 19'd0);
  assign acc_sum = {mul_hi, acc_q[20:1]};

  // Divide step: trial subtract of the total sample count
  assign div_trial = {rem_q, dvd_q[16]} - {1'b0, tot_q};
  assign div_ge    = !div_trial[22];

  // Thresholds from the sample rate
  assign four_sec = 21'({rate_q, 2'b00});
  assign six_sec  = four_sec + 21'({rate_q, 1'b0});
  assign trip     = (tot_q > {1'b0, six_sec});

  // Gain decision on the new average
  assign lower = (dvd_q > aga_pkg::LOWER_HI) ||
                 ((dvd_q > aga_pkg::LOWER_LO) && (gain_q > aga_pkg::Q_ONE));
  assign raise = !lower && (dvd_q < aga_pkg::RAISE_LIM) && (gain_q < aga_pkg::Q_ONE);
  assign dg    = lower ? times10(gain_q) : times11(gain_q);
  assign da    = lower ? times10(dvd_q)  : times11(dvd_q);

  // Constant-ratio scaling steps
  assign sdiv    = lower_q ? aga_pkg::DIV_DOWN : aga_pkg::DIV_UP;
  assign sg_step = scale_step(sg_rem_q, sg_sh_q, sdiv);
  assign sa_step = scale_step(sa_rem_q, sa_sh_q, sdiv);

  // Next state and datapath
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q;
    ch_d      = ch_q;
    vol_d     = vol_q;
    n_d       = n_q;
    upd_d     = upd_q;
    avg_m_d   = avg_m_q;
    cnt_sh_d  = cnt_sh_q;
    n_sh_d    = n_sh_q;
    acc_d     = acc_q;
    tot_d     = tot_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    bit_d     = bit_q;
    gain_d    = gain_q;
    avg_d     = avg_q;
    cnt_new_d = cnt_new_q;
    adj_d     = adj_q;
    lower_d   = lower_q;
    sg_rem_d  = sg_rem_q;
    sg_sh_d   = sg_sh_q;
    sa_rem_d  = sa_rem_q;
    sa_sh_d   = sa_sh_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    s_axis_tready = (state_q == aga_pkg::ST_IDLE);

    // Drop the output once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      aga_pkg::ST_IDLE: begin
        if (in_acc) begin
          ch_d    = s_axis_tuser;
          vol_d   = s_axis_tdata[16:0];
          n_d     = s_axis_tdata[32:17];
          state_d = aga_pkg::ST_READ;
        end
      end
      aga_pkg::ST_READ: begin
        state_d = aga_pkg::ST_LOAD;
      end
      aga_pkg::ST_LOAD: begin
        gain_d   = cur_entry.gain;
        avg_d    = cur_entry.avg;
        avg_m_d  = cur_entry.avg;
        cnt_sh_d = cur_entry.cnt;
        n_sh_d   = n_q;
        tot_d    = {1'b0, cur_entry.cnt} + {6'd0, n_q};
        acc_d    = '0;
        bit_d    = '0;
        adj_d    = aga_pkg::ADJ_NONE;
        upd_d    = in_range && (n_q != 16'd0);
        state_d  = (in_range && (n_q != 16'd0)) ? aga_pkg::ST_MUL : aga_pkg::ST_DONE;
      end
      aga_pkg::ST_MUL: begin
        acc_d    = acc_sum;
        cnt_sh_d = {1'b0, cnt_sh_q[20:1]};
        n_sh_d   = {1'b0, n_sh_q[15:1]};
        bit_d    = bit_q + 5'd1;
        if (bit_q == 5'd20) begin
          rem_d   = acc_sum[38:17];
          dvd_d   = acc_sum[16:0];
          bit_d   = '0;
          state_d = aga_pkg::ST_DIV;
        end
      end
      aga_pkg::ST_DIV: begin
        rem_d = div_ge ? div_trial[21:0] : {rem_q[20:0], dvd_q[16]};
        dvd_d = {dvd_q[15:0], div_ge};
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'd16) begin
          state_d = aga_pkg::ST_DECIDE;
        end
      end
      aga_pkg::ST_DECIDE: begin
        avg_d = dvd_q;
        if (!trip) begin
          cnt_new_d = tot_q[20:0];
          state_d   = aga_pkg::ST_DONE;
        end else begin
          cnt_new_d = four_sec;
          if (lower || raise) begin
            lower_d  = lower;
            adj_d    = lower ? aga_pkg::ADJ_DOWN : aga_pkg::ADJ_UP;
            sg_rem_d = {1'b0, dg[20:18]};
            sg_sh_d  = dg[17:0];
            sa_rem_d = {1'b0, da[20:18]};
            sa_sh_d  = da[17:0];
            bit_d    = '0;
            state_d  = aga_pkg::ST_SCALE;
          end else begin
            state_d = aga_pkg::ST_DONE;
          end
        end
      end
      aga_pkg::ST_SCALE: begin
        sg_rem_d = sg_step[21:18];
        sg_sh_d  = sg_step[17:0];
        sa_rem_d = sa_step[21:18];
        sa_sh_d  = sa_step[17:0];
        bit_d    = bit_q + 5'd1;
        if (bit_q == 5'd17) begin
          gain_d  = sat17(sg_step[17:0]);
          avg_d   = sat17(sa_step[17:0]);
          state_d = aga_pkg::ST_DONE;
        end
      end
      aga_pkg::ST_DONE: begin
        // Hold until the output register is free, then commit
        if (out_free) begin
          mem_we    = upd_q;
          m_valid_d = 1'b1;
          m_user_d  = ch_q;
          m_data_d  = in_range ? {4'b0000, adj_q, avg_q, gain_q} : 40'd0;
          state_d   = aga_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aga_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aga_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: output valid, channel valid bits, sample rate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      valid_q   <= '0;
      rate_q    <= aga_pkg::RATE_RESET;
    end else begin
      m_valid_q <= m_valid_d;
      if (mem_we) begin
        valid_q[addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        rate_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    vol_q     <= vol_d;
    n_q       <= n_d;
    upd_q     <= upd_d;
    avg_m_q   <= avg_m_d;
    cnt_sh_q  <= cnt_sh_d;
    n_sh_q    <= n_sh_d;
    acc_q     <= acc_d;
    tot_q     <= tot_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    bit_q     <= bit_d;
    gain_q    <= gain_d;
    avg_q     <= avg_d;
    cnt_new_q <= cnt_new_d;
    adj_q     <= adj_d;
    lower_q   <= lower_d;
    sg_rem_q  <= sg_rem_d;
    sg_sh_q   <= sg_sh_d;
    sa_rem_q  <= sa_rem_d;
    sa_sh_q   <= sa_sh_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  // Channel memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chan_mem_q[addr] <= wr_entry;
    end
    rd_entry_q <= chan_mem_q[addr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Checks
  assign out_oor = ({4'b0000, m_axis_tuser} >= 7'(CHANNELS));

  `AGA_ASSERT_IMPL(a_oor_zero, clk_i, rst_ni, m_axis_tvalid && out_oor, m_axis_tdata == 40'd0)
  `AGA_ASSERT_NEXT(a_done_hold, clk_i, rst_ni, (state_q == aga_pkg::ST_DONE) && !out_free, (state_q == aga_pkg::ST_DONE) && m_valid_q)
  `AGA_ASSERT_IMPL(a_div_rem, clk_i, rst_ni, state_q == aga_pkg::ST_DIV, rem_q < tot_q)
  `AGA_ASSERT_IMPL(a_up_bound, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[35:34] == aga_pkg::ADJ_UP), m_axis_tdata[16:0] <= aga_pkg::GAIN_UP_MAX)

endmodule
